// ===== src/swm_pkg.sv =====
// shared types for the sliding window maximum unit
`default_nettype none
package swm_pkg;

  typedef struct packed {
    logic load;
    logic last;
  } swm_res_ctl_t;

endpackage
`default_nettype wire

// ===== src/sliding_window_maximum_unit.sv =====
// Sliding window maximum over signed samples. Each transaction on the input
// channel carries one sample and a last flag. Once the window of window_size
// samples is full, every sample produces the maximum of the last window_size
// samples; a sequence that ends before the window fills produces one result,
// the maximum of all its samples, and all state restarts after a last sample.
// The window lives in a ram with separate write and registered read ports,
// and one comparator does all the work: a fill sample is written from idle,
// with a result once the window is full or the sample is last; a sample into
// a full window first reads the sample about to leave, and one that evicts
// the current maximum forces a rescan of the stored window, one ram read per
// cycle. The input stalls while a sample is in flight. A write of window_size
// (zero is taken as 1, values above WINDOW_MAX as WINDOW_MAX) also restarts
// the current sequence. The user must write it only while idle; not enforced.
`default_nettype none
module sliding_window_maximum_unit #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [6:0]              cfg_window_size,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                    in_last_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [SAMPLE_WIDTH-1:0] out_window_max,
  output logic                         out_last_out
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [31:0]             k_wide;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_max_r;
  logic                    out_last_r;
  logic                    busy;
  logic                    out_free;
  swm_res_ctl_t            res_ctl;
  logic [SAMPLE_WIDTH-1:0] res_max;

  always_comb begin
    k_wide = {25'd0, cfg_window_size};
    priority if (k_wide == 32'd0) begin
      k_wide = 32'd1;
    end else if (k_wide > 32'(WINDOW_MAX)) begin
      k_wide = 32'(WINDOW_MAX);
    end
    k_nxt = cfg_we ? k_wide[CNT_W-1:0] : k_r;
  end

  assign out_free = !out_valid_r || !out_stall;

  swm_seq #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .win_k      (k_r),
    .in_accept  (in_valid && !in_stall),
    .in_sample  (in_sample),
    .in_last_in (in_last_in),
    .out_free   (out_free),
    .busy       (busy),
    .res_ctl    (res_ctl),
    .res_max    (res_max)
  );

  assign in_stall = busy;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_ctl.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.load) begin
      out_max_r  <= res_max;
      out_last_r <= res_ctl.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;
  assign out_last_out   = out_last_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_ctl.load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) && (32'(k_r) <= 32'(WINDOW_MAX)))
    else $error("window size out of range");

  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ctl.load && !cfg_we) |=> !in_stall)
    else $error("input still stalled after result hand-off");
`endif

endmodule
`default_nettype wire

// ===== src/swm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/swm_seq.sv =====
// sequencer and shared compare unit: window fill, eviction check and rescan
`default_nettype none
module swm_seq #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32,
  parameter int CNT_W        = $clog2(WINDOW_MAX + 1),
  parameter int PTR_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        restart,
  input  wire logic [CNT_W-1:0]            win_k,
  input  wire logic                        in_accept,
  input  wire logic [SAMPLE_WIDTH-1:0]     in_sample,
  input  wire logic                        in_last_in,
  input  wire logic                        out_free,
  output logic                             busy,
  output swm_pkg::swm_res_ctl_t            res_ctl,
  output logic      [SAMPLE_WIDTH-1:0]     res_max
);
  import swm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEAVE = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [SAMPLE_WIDTH-1:0] s_r, s_nxt;
  logic                    last_r, last_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic [PTR_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        seen_r, seen_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    rv_r, rv_nxt;
  logic                    first_r, first_nxt;

  logic                    ram_we, ram_re;
  logic [PTR_W-1:0]        ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata, ram_rdata;

  // shared compare unit
  logic [SAMPLE_WIDTH-1:0] cmp_a, cmp_b;
  logic                    cmp_gt;
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  logic [CNT_W-1:0] pos_inc;
  logic [PTR_W-1:0] pos_adv;
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_adv = (pos_inc >= win_k) ? '0 : pos_inc[PTR_W-1:0];

  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy    = (state_r != ST_IDLE);
  assign res_max = max_r;

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    last_nxt  = last_r;
    max_nxt   = max_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    idx_nxt   = idx_r;
    rv_nxt    = 1'b0;
    first_nxt = first_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = pos_r;
    ram_wdata = s_r;
    cmp_a     = in_sample;
    cmp_b     = max_r;
    res_ctl   = '0;

    unique case (state_r)
      ST_IDLE: begin
        ram_wdata = in_sample;
        if (in_accept) begin
          s_nxt    = in_sample;
          last_nxt = in_last_in;
          if (seen_r < win_k) begin
            ram_we   = 1'b1;
            pos_nxt  = pos_adv;
            seen_nxt = seen_r + CNT_W'(1);
            if (seen_r == '0 || cmp_gt) begin
              max_nxt = in_sample;
            end
            if (seen_nxt == win_k || in_last_in) begin
              state_nxt = ST_EMIT;
            end
          end else begin
            // fetch the sample about to leave the window
            ram_re    = 1'b1;
            state_nxt = ST_LEAVE;
          end
        end
      end
      ST_LEAVE: begin
        ram_we  = 1'b1;
        pos_nxt = pos_adv;
        cmp_a   = s_r;
        if (ram_rdata == max_r) begin
          idx_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          if (cmp_gt) begin
            max_nxt = s_r;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        ram_raddr = idx_r[PTR_W-1:0];
        cmp_a     = ram_rdata;
        if (idx_r < win_k) begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          if (first_r || cmp_gt) begin
            max_nxt = ram_rdata;
          end
          first_nxt = 1'b0;
          if (idx_r == win_k) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_ctl.load = 1'b1;
          res_ctl.last = last_r;
          state_nxt    = ST_IDLE;
          if (last_r) begin
            pos_nxt  = '0;
            seen_nxt = '0;
            max_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (restart) begin
      state_nxt = ST_IDLE;
      pos_nxt   = '0;
      seen_nxt  = '0;
      max_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      seen_r  <= '0;
      max_r   <= '0;
      idx_r   <= '0;
      rv_r    <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      max_r   <= max_nxt;
      idx_r   <= idx_nxt;
      rv_r    <= rv_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire
